>>> design/hwg_pkg.sv
package hwg_pkg;

   localparam int unsigned NUM_SLOTS   = 6;
   localparam int unsigned SLOT_W      = 3;
   localparam int unsigned ANGLE_W     = 10;
   localparam int unsigned CMD_ANGLE_W = 8;

   localparam logic signed [ANGLE_W-1:0] NEUTRAL_ANGLE = 10'sd90;
   localparam logic [CMD_ANGLE_W-1:0]    MAX_ANGLE     = 8'd180;

   // command slot within one wave-gait group
   localparam logic [3:0] SUB_LAST     = 4'd9;
   localparam logic [2:0] FINAL_GROUP  = 3'd6;

   // csr register indexes
   localparam logic [1:0] CSR_STRIDE_FRONT  = 2'd0;
   localparam logic [1:0] CSR_STRIDE_MIDDLE = 2'd1;
   localparam logic [1:0] CSR_LIFT_ANGLE    = 2'd2;
   localparam logic [1:0] CSR_PAUSE_TICKS   = 2'd3;

   localparam logic KIND_SET   = 1'b0;
   localparam logic KIND_WAIT  = 1'b1;
   localparam logic JOINT_HIP  = 1'b0;
   localparam logic JOINT_KNEE = 1'b1;

   // operand selection for the shared add/saturate unit
   typedef enum logic [2:0] {
      OP_NEUTRAL = 3'd0,
      OP_LIFT    = 3'd1,
      OP_SWING   = 3'd2,
      OP_PUSH    = 3'd3,
      OP_WAIT    = 3'd4
   } hwg_op_type;

   typedef struct packed {
      logic              busy;
      hwg_op_type        op;
      logic [SLOT_W-1:0] slot;
      logic              joint;
      logic              last;
   } hwg_ctl_type;

   // floor(2*stride/5): multiply by 205/1024, exact for inputs below 256
   function automatic logic [5:0] push_of(input logic [6:0] stride);
      logic [15:0] prod;
      prod = {8'd0, stride, 1'b0} * 16'd205;
      return prod[15:10];
   endfunction

endpackage

>>> design/hwg_alu.sv
module hwg_alu (
   input  logic signed [hwg_pkg::ANGLE_W-1:0]     op_a,
   input  logic signed [hwg_pkg::ANGLE_W-1:0]     op_b,
   output logic signed [hwg_pkg::ANGLE_W-1:0]     sum_out,
   output logic        [hwg_pkg::CMD_ANGLE_W-1:0] sat_out
);

   logic signed [hwg_pkg::ANGLE_W:0] sum_full;

   assign sum_full = {op_a[hwg_pkg::ANGLE_W-1], op_a} + {op_b[hwg_pkg::ANGLE_W-1], op_b};
   assign sum_out  = sum_full[hwg_pkg::ANGLE_W-1:0];

   // clamp to the servo range
   always_comb begin
      if (sum_out < 0) begin
         sat_out = '0;
      end else if (sum_out > $signed({2'b00, hwg_pkg::MAX_ANGLE})) begin
         sat_out = hwg_pkg::MAX_ANGLE;
      end else begin
         sat_out = sum_out[hwg_pkg::CMD_ANGLE_W-1:0];
      end
   end

endmodule

>>> design/hwg_seq.sv
module hwg_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 advance,
   output hwg_pkg::hwg_ctl_type ctl
);

   logic       busy_ff, busy_in;
   logic [2:0] grp_ff, grp_in;
   logic [3:0] sub_ff, sub_in;
   logic       final_grp;
   logic [3:0] offset;
   logic [3:0] slot_sum;

   assign final_grp = (grp_ff == hwg_pkg::FINAL_GROUP);

   // slot: group leg for the knee drop, next leg up to the swing, then walk on
   always_comb begin
      if (sub_ff == 4'd0) begin
         offset = 4'd0;
      end else if (sub_ff inside {[4'd4:4'd9]}) begin
         offset = sub_ff - 4'd2;
      end else begin
         offset = 4'd1;
      end
      slot_sum = {1'b0, grp_ff} + offset;
      if (slot_sum >= 4'd6) begin
         slot_sum = slot_sum - 4'd6;
      end
   end

   always_comb begin
      ctl.busy  = busy_ff;
      ctl.slot  = slot_sum[2:0];
      ctl.last  = final_grp && (sub_ff == 4'd1);
      ctl.joint = hwg_pkg::JOINT_HIP;
      case (sub_ff)
         4'd0: begin
            ctl.op    = hwg_pkg::OP_NEUTRAL;
            ctl.joint = hwg_pkg::JOINT_KNEE;
         end
         4'd1: begin
            ctl.op    = final_grp ? hwg_pkg::OP_WAIT : hwg_pkg::OP_LIFT;
            ctl.joint = final_grp ? hwg_pkg::JOINT_HIP : hwg_pkg::JOINT_KNEE;
         end
         4'd2:                   ctl.op = hwg_pkg::OP_WAIT;
         4'd3:                   ctl.op = hwg_pkg::OP_SWING;
         4'd4, 4'd5, 4'd6, 4'd7,
         4'd8:                   ctl.op = hwg_pkg::OP_PUSH;
         default:                ctl.op = hwg_pkg::OP_WAIT;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      grp_in  = grp_ff;
      sub_in  = sub_ff;
      if (start) begin
         busy_in = 1'b1;
         grp_in  = '0;
         sub_in  = '0;
      end else if (busy_ff && advance) begin
         if (ctl.last) begin
            busy_in = 1'b0;
         end else if (sub_ff == hwg_pkg::SUB_LAST) begin
            sub_in = '0;
            grp_in = grp_ff + 3'd1;
         end else begin
            sub_in = sub_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         grp_ff  <= '0;
         sub_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         grp_ff  <= grp_in;
         sub_ff  <= sub_in;
      end
   end

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (sub_ff <= hwg_pkg::SUB_LAST && grp_ff <= hwg_pkg::FINAL_GROUP))
      else $error("sequencer step out of range");

   a_final_short: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && final_grp) |-> (sub_ff <= 4'd1))
      else $error("final group runs past its wait");

endmodule

>>> design/hexapod_wave_gait_sequencer_unit.sv
// channel | direction | handshake         | payload
// req     | in        | req_valid/stall   | direction, restart
// rsp     | out       | rsp_valid/stall   | cmd_kind, leg, joint, servo_angle, wait_ticks, last
// csr     | in        | csr_we            | csr_index, csr_wdata
//
// One request yields 62 commands, one per cycle through a shared add/saturate
// unit while the result side does not stall.
// req_stall stays high from acceptance until the last command enters the
// output register. A rsp_stall while rsp_valid is high holds the output register and the sequencer.
// Synchronous reset restores register defaults and all hip angles to 90.
module hexapod_wave_gait_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_direction,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_cmd_kind,
   output logic [2:0]  rsp_leg,
   output logic        rsp_joint,
   output logic [7:0]  rsp_servo_angle,
   output logic [15:0] rsp_wait_ticks,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   hwg_pkg::hwg_ctl_type ctl;

   logic [6:0]  stride_front_ff;
   logic [6:0]  stride_middle_ff;
   logic [7:0]  lift_angle_ff;
   logic [15:0] pause_ticks_ff;

   logic [2:0]  order_ff [hwg_pkg::NUM_SLOTS];
   logic [2:0]  order_in [hwg_pkg::NUM_SLOTS];
   logic [5:0]  push_front_ff, push_middle_ff;
   logic signed [hwg_pkg::ANGLE_W-1:0] running_ff [hwg_pkg::NUM_SLOTS];

   logic        rsp_valid_ff;
   logic        kind_ff, joint_ff, last_ff;
   logic [2:0]  leg_ff;
   logic [7:0]  angle_ff;
   logic [15:0] ticks_ff;

   logic        start, load_ok, load;
   logic [3:0]  t2, t4;
   logic [2:0]  o2, o4;
   logic        is_middle, is_rear_side;
   logic [6:0]  dist_mag;
   logic [5:0]  push_mag;
   logic signed [hwg_pkg::ANGLE_W-1:0] op_a, op_b, alu_sum;
   logic [7:0]  alu_sat;
   logic        is_wait, writes_angle;

   assign start     = req_valid && !ctl.busy;
   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign load      = ctl.busy && load_ok;
   assign req_stall = ctl.busy;

   hwg_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .advance (load_ok),
      .ctl     (ctl)
   );

   // leg order from direction, mod-6 by compare and subtract
   always_comb begin
      t2 = {1'b0, req_direction} + 4'd1;
      if (t2 >= 4'd6) t2 = t2 - 4'd6;
      o2 = t2[2:0] + 3'd1;
      t4 = {1'b0, o2} + 4'd1;
      if (t4 >= 4'd6) t4 = t4 - 4'd6;
      o4 = t4[2:0] + 3'd1;
      order_in[0] = req_direction;
      order_in[1] = 3'd7 - o4;
      order_in[2] = o2;
      order_in[3] = 3'd7 - o2;
      order_in[4] = o4;
      order_in[5] = 3'd7 - req_direction;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         order_ff       <= order_in;
         push_front_ff  <= hwg_pkg::push_of(stride_front_ff);
         push_middle_ff <= hwg_pkg::push_of(stride_middle_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_front_ff  <= 7'd70;
         stride_middle_ff <= 7'd50;
         lift_angle_ff    <= 8'd40;
         pause_ticks_ff   <= 16'd100;
      end else if (csr_we) begin
         case (csr_index)
            hwg_pkg::CSR_STRIDE_FRONT:  stride_front_ff  <= csr_wdata[6:0];
            hwg_pkg::CSR_STRIDE_MIDDLE: stride_middle_ff <= csr_wdata[6:0];
            hwg_pkg::CSR_LIFT_ANGLE:    lift_angle_ff    <= csr_wdata[7:0];
            hwg_pkg::CSR_PAUSE_TICKS:   pause_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front-side slots swing back, rear-side slots swing forward
   assign is_middle    = (ctl.slot == 3'd1) || (ctl.slot == 3'd4);
   assign is_rear_side = (ctl.slot <= 3'd2);
   assign dist_mag     = is_middle ? stride_middle_ff : stride_front_ff;
   assign push_mag     = is_middle ? push_middle_ff : push_front_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctl.op)
         hwg_pkg::OP_NEUTRAL: op_a = hwg_pkg::NEUTRAL_ANGLE;
         hwg_pkg::OP_LIFT:    op_a = $signed({2'b00, lift_angle_ff});
         hwg_pkg::OP_SWING: begin
            op_a = hwg_pkg::NEUTRAL_ANGLE;
            op_b = is_rear_side ? -$signed({3'b000, dist_mag})
                                :  $signed({3'b000, dist_mag});
         end
         hwg_pkg::OP_PUSH: begin
            op_a = running_ff[ctl.slot];
            op_b = is_rear_side ?  $signed({4'b0000, push_mag})
                                : -$signed({4'b0000, push_mag});
         end
         default: ;
      endcase
   end

   hwg_alu u_alu (
      .op_a    (op_a),
      .op_b    (op_b),
      .sum_out (alu_sum),
      .sat_out (alu_sat)
   );

   assign is_wait      = (ctl.op == hwg_pkg::OP_WAIT);
   assign writes_angle = (ctl.op == hwg_pkg::OP_SWING) || (ctl.op == hwg_pkg::OP_PUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < hwg_pkg::NUM_SLOTS; k++) begin
            running_ff[k] <= hwg_pkg::NEUTRAL_ANGLE;
         end
      end else if (start && req_restart) begin
         for (int k = 0; k < hwg_pkg::NUM_SLOTS; k++) begin
            running_ff[k] <= hwg_pkg::NEUTRAL_ANGLE;
         end
      end else if (load && writes_angle) begin
         running_ff[ctl.slot] <= alu_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_ok) begin
         rsp_valid_ff <= ctl.busy;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= is_wait ? hwg_pkg::KIND_WAIT : hwg_pkg::KIND_SET;
         leg_ff   <= is_wait ? 3'd0 : order_ff[ctl.slot];
         joint_ff <= is_wait ? hwg_pkg::JOINT_HIP : ctl.joint;
         angle_ff <= is_wait ? 8'd0 : alu_sat;
         ticks_ff <= is_wait ? pause_ticks_ff : 16'd0;
         last_ff  <= ctl.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cmd_kind    = kind_ff;
   assign rsp_leg         = leg_ff;
   assign rsp_joint       = joint_ff;
   assign rsp_servo_angle = angle_ff;
   assign rsp_wait_ticks  = ticks_ff;
   assign rsp_last        = last_ff;

   a_last_is_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_cmd_kind == hwg_pkg::KIND_WAIT))
      else $error("final command is not a wait");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cmd_kind == hwg_pkg::KIND_SET) |-> (rsp_servo_angle <= hwg_pkg::MAX_ANGLE))
      else $error("servo angle beyond range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer not busy after request");

endmodule
